// ===== rtl/cooperative_task_tick_scheduler_assert.svh =====
// Assertion macros used by the scheduler's RTL.
`ifndef COOPERATIVE_TASK_TICK_SCHEDULER_ASSERT_SVH
`define COOPERATIVE_TASK_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CTTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cooperative_task_tick_scheduler: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cooperative_task_tick_scheduler: next-cycle check failed");

`endif

// ===== rtl/ctts_pkg.sv =====
package ctts_pkg;

  localparam int unsigned ValW       = 16;
  localparam int unsigned HandleW    = 16;
  localparam int unsigned RunsW      = 8;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned TslotW     = 3;
  localparam int unsigned ResCntW    = 4;
  localparam int unsigned MaxResults = 8;

  localparam logic [RunsW-1:0] RunsMax = '1;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_RUN    = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  // One slot of the task table.
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [ValW-1:0]    delay;
    logic [ValW-1:0]    period;
    logic [RunsW-1:0]   runs;
  } entry_t;

  // Per-cycle commands from the sequencer to the slot memory.
  typedef struct packed {
    logic re;
    logic we;
    logic clr;
  } mem_ctrl_t;

endpackage

// ===== rtl/ctts_if.sv =====
interface ctts_in_if;
  import ctts_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [TslotW-1:0]   task_slot;
  logic [HandleW-1:0]  task_handle;
  logic [ValW-1:0]     delay_ms;
  logic [ValW-1:0]     period_ms;

  modport source (
    output valid, action, task_slot, task_handle, delay_ms, period_ms,
    input  ready
  );
  modport sink (
    input  valid, action, task_slot, task_handle, delay_ms, period_ms,
    output ready
  );
endinterface

interface ctts_out_if;
  import ctts_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [SlotW-1:0]   slot;
  logic [HandleW-1:0] handle;
  logic               was_empty;
  logic               last;

  modport source (
    output valid, kind, slot, handle, was_empty, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, handle, was_empty, last,
    output ready
  );
endinterface

// ===== rtl/ctts_div.sv =====
module ctts_div #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ctts_pkg::ValW-1:0] dividend_i,
  output logic                      done_o,
  output logic [ctts_pkg::ValW-1:0] quo_o
);
  import ctts_pkg::*;

  // Division by the tick length is a multiplication by its rounded-up
  // reciprocal. With the shift at ValW plus the bits of TICK_MS, the
  // reciprocal fits in ValW+1 bits and the quotient is exact for every
  // ValW-bit dividend.
  localparam int unsigned    Shift     = ValW + $clog2(TICK_MS);
  localparam longint unsigned RecipFull =
    ((64'd1 << Shift) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [ValW:0]  Recip     = (ValW+1)'(RecipFull);
  localparam int unsigned    ProdW     = 2 * ValW + 1;

  logic             done_q;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] prod;

  assign prod = ProdW'(dividend_i) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod;
    end
  end

  assign done_o = done_q;
  assign quo_o  = ValW'(prod_q >> Shift);

endmodule

// ===== rtl/ctts_mem.sv =====
module ctts_mem #(
  parameter int unsigned NUM_TASKS = 8,
  parameter int unsigned AW        = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctts_pkg::mem_ctrl_t   ctrl_i,
  input  logic [AW-1:0]         raddr_i,
  input  logic [AW-1:0]         waddr_i,
  input  ctts_pkg::entry_t      wdata_i,
  output ctts_pkg::entry_t      rdata_o
);
  import ctts_pkg::*;

  entry_t               mem_q [NUM_TASKS];
  logic [NUM_TASKS-1:0] valid_q;
  entry_t               rdata_q;
  logic                 rvalid_q;

  // A slot that was never written, or was cleared, reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end else if (ctrl_i.clr) begin
        valid_q[waddr_i] <= 1'b0;
      end
      if (ctrl_i.re) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/cooperative_task_tick_scheduler.sv =====
// Channel  Role    Handshake     Payload
// in_i     sink    valid/ready   action, task_slot, task_handle, delay_ms, period_ms
// out_o    source  valid/ready   kind, slot, handle, was_empty, last
//
// Tick: the sequencer visits each slot in turn, a registered memory read followed by
// the update through the shared slot datapath. Add first divides delay and then period
// by TICK_MS in the reciprocal multiplier, then searches the slots in order for a free
// one, or through all of them when the table is full. Delete skips the table for a slot
// outside it and otherwise reads and clears that slot; dispatch walks every slot.
// Output back-pressure can stall an add, a delete or a dispatch.
// Reset is asynchronous and active low; the table reads as empty at once, with no
// clearing pass. A stalled output holds its transaction in the output register.
module cooperative_task_tick_scheduler #(
  parameter int unsigned NUM_TASKS = 8,
  parameter int unsigned TICK_MS   = 10
) (
  input logic         clk_i,
  input logic         rst_ni,
  ctts_in_if.sink     in_i,
  ctts_out_if.source  out_o
);
  import ctts_pkg::*;

  // Slot address width, and the width of the slot counter, which must also
  // hold NUM_TASKS itself.
  localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CW = $clog2(NUM_TASKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVD = 3'd1;
  localparam logic [2:0] S_DIVP = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [ResCntW-1:0] nres_q, nres_d;

  // Latched input transaction; the period register later holds its quotient.
  action_e act_q, act_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [ValW-1:0] dly_q, dly_d;
  logic [ValW-1:0] per_q, per_d;

  // The result being built. During a dispatch pass it holds the latest hit,
  // which can only be sent once it is known whether another hit follows.
  kind_e res_kind_q, res_kind_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  logic res_empty_q, res_empty_d;

  // Output register.
  logic out_valid_q;
  kind_e out_kind_q;
  logic [SlotW-1:0] out_slot_q;
  logic [HandleW-1:0] out_handle_q;
  logic out_empty_q;
  logic out_last_q;
  logic out_load;
  logic out_last_n;
  logic out_free;

  // Shared divider.
  logic div_start;
  logic [ValW-1:0] div_arg;
  logic div_done;
  logic [ValW-1:0] div_quo;

  // Slot memory.
  mem_ctrl_t mem_ctrl;
  entry_t wr_entry;
  entry_t rd_entry;

  // Slot datapath.
  logic occupied;
  logic hit;
  logic idx_last;
  entry_t tick_entry;
  entry_t run_entry;

  ctts_div #(
    .TICK_MS (TICK_MS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_arg),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  ctts_mem #(
    .NUM_TASKS (NUM_TASKS),
    .AW        (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .raddr_i (idx_q[AW-1:0]),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Datapath for one slot, shared by every action. A slot whose delay has run
  // out gains a pending run, saturating, and reloads its period; a one-shot
  // task thus keeps a delay of zero and gains a run on every later tick.
  always_comb begin
    occupied = (rd_entry.handle != '0);
    hit      = occupied && (rd_entry.runs != '0) && (nres_q < ResCntW'(MaxResults));
    idx_last = (idx_q == CW'(NUM_TASKS - 1));

    tick_entry = rd_entry;
    if (rd_entry.delay <= ValW'(1)) begin
      if (rd_entry.runs != RunsMax) begin
        tick_entry.runs = rd_entry.runs + 1'b1;
      end
      tick_entry.delay = rd_entry.period;
    end else begin
      tick_entry.delay = rd_entry.delay - 1'b1;
    end

    run_entry      = rd_entry;
    run_entry.runs = rd_entry.runs - 1'b1;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    nres_d       = nres_q;
    act_d        = act_q;
    handle_d     = handle_q;
    dly_d        = dly_q;
    per_d        = per_q;
    res_kind_d   = res_kind_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_empty_d  = res_empty_q;
    mem_ctrl     = '0;
    wr_entry     = rd_entry;
    div_start    = 1'b0;
    div_arg      = in_i.delay_ms;
    out_load     = 1'b0;
    out_last_n   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d    = action_e'(in_i.action);
          handle_d = in_i.task_handle;
          per_d    = in_i.period_ms;
          idx_d    = '0;
          nres_d   = '0;
          unique case (action_e'(in_i.action))
            ACT_TICK: begin
              state_d = S_RD;
            end
            ACT_ADD: begin
              div_start = 1'b1;
              div_arg   = in_i.delay_ms;
              state_d   = S_DIVD;
            end
            ACT_DELETE: begin
              // A slot beyond the table is reported as empty and left alone.
              if (7'(in_i.task_slot) < 7'(NUM_TASKS)) begin
                idx_d   = CW'(in_i.task_slot);
                state_d = S_RD;
              end else begin
                res_kind_d   = KIND_DELETE;
                res_slot_d   = SlotW'(in_i.task_slot);
                res_handle_d = '0;
                res_empty_d  = 1'b1;
                state_d      = S_EMIT;
              end
            end
            ACT_DISPATCH: begin
              state_d = S_RD;
            end
          endcase
        end
      end

      S_DIVD: begin
        if (div_done) begin
          dly_d     = div_quo;
          div_start = 1'b1;
          div_arg   = per_q;
          state_d   = S_DIVP;
        end
      end

      S_DIVP: begin
        if (div_done) begin
          per_d   = div_quo;
          state_d = S_RD;
        end
      end

      S_RD: begin
        mem_ctrl.re = 1'b1;
        state_d     = S_EX;
      end

      S_EX: begin
        unique case (act_q)
          ACT_TICK: begin
            if (occupied) begin
              mem_ctrl.we = 1'b1;
              wr_entry    = tick_entry;
            end
            idx_d   = idx_q + 1'b1;
            state_d = idx_last ? S_IDLE : S_RD;
          end

          ACT_ADD: begin
            res_kind_d   = KIND_ADD;
            res_handle_d = '0;
            res_empty_d  = 1'b0;
            if (!occupied) begin
              mem_ctrl.we     = 1'b1;
              wr_entry.handle = handle_q;
              wr_entry.delay  = dly_q;
              wr_entry.period = per_q;
              wr_entry.runs   = '0;
              res_slot_d      = SlotW'(idx_q);
              state_d         = S_EMIT;
            end else if (idx_last) begin
              // Table full: the reply carries NUM_TASKS in the slot field.
              res_slot_d = SlotW'(NUM_TASKS);
              state_d    = S_EMIT;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end

          ACT_DELETE: begin
            mem_ctrl.clr = 1'b1;
            res_kind_d   = KIND_DELETE;
            res_slot_d   = SlotW'(idx_q);
            res_handle_d = '0;
            res_empty_d  = !occupied;
            state_d      = S_EMIT;
          end

          ACT_DISPATCH: begin
            // A new hit pushes the previous one out, which then is not last;
            // wait here while the output register is still full.
            if (!(hit && (nres_q != '0) && !out_free)) begin
              if (hit) begin
                if (nres_q != '0) begin
                  out_load   = 1'b1;
                  out_last_n = 1'b0;
                end
                res_kind_d   = KIND_RUN;
                res_slot_d   = SlotW'(idx_q);
                res_handle_d = rd_entry.handle;
                res_empty_d  = 1'b0;
                nres_d       = nres_q + 1'b1;
                if (rd_entry.period == '0) begin
                  mem_ctrl.clr = 1'b1;
                end else begin
                  mem_ctrl.we = 1'b1;
                  wr_entry    = run_entry;
                end
              end
              idx_d   = idx_q + 1'b1;
              state_d = idx_last ? S_FIN : S_RD;
            end
          end
        endcase
      end

      S_FIN: begin
        if (nres_q == '0) begin
          res_kind_d   = KIND_IDLE;
          res_slot_d   = '0;
          res_handle_d = '0;
          res_empty_d  = 1'b0;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_n = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nres_q  <= nres_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    handle_q     <= handle_d;
    dly_q        <= dly_d;
    per_q        <= per_d;
    res_kind_q   <= res_kind_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_empty_q  <= res_empty_d;
    if (out_load) begin
      out_kind_q   <= res_kind_q;
      out_slot_q   <= res_slot_q;
      out_handle_q <= res_handle_q;
      out_empty_q  <= res_empty_q;
      out_last_q   <= out_last_n;
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.slot      = out_slot_q;
  assign out_o.handle    = out_handle_q;
  assign out_o.was_empty = out_empty_q;
  assign out_o.last      = out_last_q;

  `include "cooperative_task_tick_scheduler_assert.svh"

  // Every accepted action takes the sequencer out of the idle state.
  `CTTS_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, state_q != S_IDLE)
  // The slot datapath only ever works on a slot inside the table.
  `CTTS_ASSERT_IMPL(a_slot_in_range, state_q == S_EX, idx_q < CW'(NUM_TASKS))
  // Only a dispatch pass sends results that are not the final one.
  `CTTS_ASSERT_IMPL(a_nonlast_is_run, out_valid_q && !out_last_q, out_kind_q == KIND_RUN)

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctts_pkg::*;

  // Build-time shape of the block under test.
  localparam int unsigned Slots       = 8;
  localparam int unsigned TickMs      = 10;
  // The receiver holds off for this many cycles while the sender keeps offering.
  localparam int unsigned HoldCycles  = 300;
  // Extra cycles after the last expected transaction.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned MixItems    = 120;
  localparam int unsigned CalmItems   = 40;
  localparam int unsigned StormTicks  = 258;
  localparam int unsigned PlanLen     = 25;

  // One transaction on the output channel.
  typedef struct packed {
    kind_e              kind;
    logic [SlotW-1:0]   slot;
    logic [HandleW-1:0] handle;
    logic               was_empty;
    logic               last;
  } sched_res_t;

  // One command for the scheduler. When typed is set, the expected reply is
  // written out by hand and replaces the predicted one.
  typedef struct {
    action_e            act;
    logic [TslotW-1:0]  tslot;
    logic [HandleW-1:0] handle;
    logic [ValW-1:0]    dly_ms;
    logic [ValW-1:0]    per_ms;
    bit                 typed;
    sched_res_t         typed_res;
  } sched_cmd_t;

  // A row of the directed table. Typed rows always give a single reply with
  // a zero handle and last set, so only kind, slot and was_empty are listed.
  typedef struct packed {
    action_e            act;
    logic [TslotW-1:0]  tslot;
    logic [HandleW-1:0] handle;
    logic [ValW-1:0]    dly_ms;
    logic [ValW-1:0]    per_ms;
    logic               typed;
    kind_e              t_kind;
    logic [SlotW-1:0]   t_slot;
    logic               t_empty;
  } plan_row_t;

  // The directed part. The table starts empty, so the first replies can be
  // read straight off: an idle dispatch, a delete of an empty slot, and adds
  // that land in ascending slots. The zero-handle add names slot 2 but leaves
  // it empty, so the next add lands there again. Later the table is filled
  // until an add reports it full.
  localparam plan_row_t Plan [PlanLen] = '{
    '{ACT_DISPATCH, 3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE,   4'd0, 1'b0},
    '{ACT_DELETE,   3'd3, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_DELETE, 4'd3, 1'b1},
    '{ACT_ADD,      3'd7, 16'hFFFF, 16'd0,    16'd0,    1'b1, KIND_ADD,    4'd0, 1'b0},
    '{ACT_ADD,      3'd0, 16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, KIND_ADD,    4'd1, 1'b0},
    '{ACT_ADD,      3'd5, 16'h0000, 16'd20,   16'd10,   1'b1, KIND_ADD,    4'd2, 1'b0},
    '{ACT_ADD,      3'd2, 16'h8001, 16'd9,    16'd19,   1'b1, KIND_ADD,    4'd2, 1'b0},
    '{ACT_TICK,     3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_DISPATCH, 3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_TICK,     3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_TICK,     3'd5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_DISPATCH, 3'd2, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_DISPATCH, 3'd6, 16'h1111, 16'h2222, 16'h3333, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_DISPATCH, 3'd1, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_ADD,      3'd0, 16'h1234, 16'd0,    16'd10,   1'b1, KIND_ADD,    4'd0, 1'b0},
    '{ACT_ADD,      3'd0, 16'h2345, 16'd15,   16'd0,    1'b1, KIND_ADD,    4'd3, 1'b0},
    '{ACT_ADD,      3'd0, 16'h3456, 16'd30,   16'd20,   1'b1, KIND_ADD,    4'd4, 1'b0},
    '{ACT_ADD,      3'd0, 16'h4567, 16'hFFFF, 16'd0,    1'b1, KIND_ADD,    4'd5, 1'b0},
    '{ACT_ADD,      3'd0, 16'h5678, 16'd5,    16'hFFFF, 1'b1, KIND_ADD,    4'd6, 1'b0},
    '{ACT_ADD,      3'd0, 16'h6789, 16'd40,   16'd50,   1'b1, KIND_ADD,    4'd7, 1'b0},
    '{ACT_ADD,      3'd0, 16'hABCD, 16'd10,   16'd10,   1'b1, KIND_ADD,    4'd8, 1'b0},
    '{ACT_DELETE,   3'd1, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_DELETE, 4'd1, 1'b0},
    '{ACT_DELETE,   3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, KIND_DELETE, 4'd1, 1'b1},
    '{ACT_ADD,      3'd4, 16'h7FFF, 16'd10,   16'd30,   1'b1, KIND_ADD,    4'd1, 1'b0},
    '{ACT_TICK,     3'd3, 16'h0F0F, 16'hF0F0, 16'h0F0F, 1'b0, KIND_ADD,    4'd0, 1'b0},
    '{ACT_DISPATCH, 3'd4, 16'hF0F0, 16'h0F0F, 16'hF0F0, 1'b0, KIND_ADD,    4'd0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ctts_in_if  in_if ();
  ctts_out_if out_if ();

  cooperative_task_tick_scheduler #(
    .NUM_TASKS(Slots),
    .TICK_MS  (TickMs)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // The predictor's own copy of the task table.
  entry_t      task_tab [Slots];
  // Replies that the block still owes, oldest first.
  sched_res_t  results_due [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  // Set for the last stretch of the run, where neither side idles.
  bit          calm;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit          hold_asked;

  always begin
    #2ns clk_i = 1'b1;
    #2ns clk_i = 1'b0;
  end

  // Prints one line per mismatch, up to a cap, and counts every one of them.
  task automatic report_mismatch(input string what);
    fail_cnt++;
    if (fail_cnt <= 100) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
  endtask

  // Works out the replies to one command and moves the table on. Delay and
  // period are scaled down to ticks on add; a tick makes a run pending when
  // the delay reaches zero and reloads the period, and the run count stops
  // at its maximum rather than wrapping. A dispatch pass reports due slots in
  // ascending order, at most MaxResults of them, and drops one-shots once run.
  function automatic void forecast(input sched_cmd_t c, ref sched_res_t got [$]);
    int unsigned idx;
    int unsigned n;
    sched_res_t  r;
    got.delete();
    r = '{kind: KIND_ADD, slot: '0, handle: '0, was_empty: 1'b0, last: 1'b1};
    case (c.act)
      ACT_TICK: begin
        foreach (task_tab[k]) begin
          if (task_tab[k].handle != '0) begin
            if (task_tab[k].delay <= 1) begin
              if (task_tab[k].runs != RunsMax) begin
                task_tab[k].runs = task_tab[k].runs + 1'b1;
              end
              task_tab[k].delay = task_tab[k].period;
            end else begin
              task_tab[k].delay = task_tab[k].delay - 1'b1;
            end
          end
        end
      end
      ACT_ADD: begin
        idx = 0;
        while (idx < Slots && task_tab[idx].handle != '0) idx++;
        if (idx < Slots) begin
          task_tab[idx] = '{handle: c.handle,
                            delay:  ValW'(c.dly_ms / TickMs),
                            period: ValW'(c.per_ms / TickMs),
                            runs:   '0};
        end
        r.slot = SlotW'(idx);
        got.push_back(r);
      end
      ACT_DELETE: begin
        r.kind      = KIND_DELETE;
        r.slot      = SlotW'(c.tslot);
        r.was_empty = 1'b1;
        if (c.tslot < Slots) begin
          r.was_empty = (task_tab[c.tslot].handle == '0);
          task_tab[c.tslot] = '0;
        end
        got.push_back(r);
      end
      default: begin
        n = 0;
        for (idx = 0; idx < Slots && n < MaxResults; idx++) begin
          if (task_tab[idx].handle != '0 && task_tab[idx].runs != '0) begin
            got.push_back('{kind: KIND_RUN, slot: SlotW'(idx),
                            handle: task_tab[idx].handle, was_empty: 1'b0, last: 1'b0});
            n++;
            task_tab[idx].runs = task_tab[idx].runs - 1'b1;
            if (task_tab[idx].period == '0) begin
              task_tab[idx] = '0;
            end
          end
        end
        if (n == 0) begin
          r.kind = KIND_IDLE;
          got.push_back(r);
        end else begin
          got[n-1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // Mostly well-formed traffic: short delays so that tasks fire often, an
  // occasional zero handle, and now and then the full range of every field.
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t  c;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    c.act    = (pick < 35) ? ACT_TICK : (pick < 60) ? ACT_ADD :
               (pick < 77) ? ACT_DELETE : ACT_DISPATCH;
    c.tslot  = TslotW'($urandom);
    c.handle = ($urandom_range(0, 15) == 0) ? '0 : HandleW'($urandom_range(1, 65535));
    c.dly_ms = ($urandom_range(0, 3) != 0) ? ValW'($urandom_range(0, 60)) : ValW'($urandom);
    pick     = $urandom_range(0, 3);
    c.per_ms = (pick == 0) ? '0 : (pick == 3) ? ValW'($urandom) :
               ValW'($urandom_range(0, 80));
    c.typed     = 1'b0;
    c.typed_res = '0;
    return c;
  endfunction

  // Drops valid for a random burst, except in the calm stretch.
  task automatic maybe_pause_sender();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Offers one command and waits for the block to take it. Valid stays high
  // afterwards, so a following offer in the same step makes no second change.
  task automatic offer(input sched_cmd_t c);
    sched_res_t fresh [$];
    maybe_pause_sender();
    in_if.valid       <= 1'b1;
    in_if.action      <= c.act;
    in_if.task_slot   <= c.tslot;
    in_if.task_handle <= c.handle;
    in_if.delay_ms    <= c.dly_ms;
    in_if.period_ms   <= c.per_ms;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    forecast(c, fresh);
    if (c.typed) begin
      results_due.push_back(c.typed_res);
    end else begin
      foreach (fresh[k]) results_due.push_back(fresh[k]);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, and none at all
  // once the calm stretch begins.
  initial begin : result_drain
    int unsigned held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked) begin
        hold_asked = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every transaction that leaves the block is matched against the oldest
  // reply still owed.
  always @(posedge clk_i) begin : result_check
    sched_res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind %0d slot %0d handle %h",
                                  out_if.kind, out_if.slot, out_if.handle));
      end else begin
        want = results_due.pop_front();
        if (out_if.kind !== want.kind) begin
          report_mismatch($sformatf("kind %0d, expected %0d", out_if.kind, want.kind));
        end
        if (out_if.slot !== want.slot) begin
          report_mismatch($sformatf("slot %0d, expected %0d", out_if.slot, want.slot));
        end
        if (out_if.handle !== want.handle) begin
          report_mismatch($sformatf("handle %h, expected %h", out_if.handle, want.handle));
        end
        if (out_if.was_empty !== want.was_empty) begin
          report_mismatch($sformatf("was_empty %b, expected %b",
                                    out_if.was_empty, want.was_empty));
        end
        if (out_if.last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", out_if.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("cooperative_task_tick_scheduler: mismatch");
    $finish;
  end

  initial begin : stimulus
    sched_cmd_t  c;
    int unsigned free_cnt;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    calm       = 1'b0;
    hold_asked = 1'b0;
    foreach (task_tab[k]) task_tab[k] = '0;
    rst_ni             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_TICK;
    in_if.task_slot   <= '0;
    in_if.task_handle <= '0;
    in_if.delay_ms    <= '0;
    in_if.period_ms   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, walked row by row.
    foreach (Plan[k]) begin
      c.act       = Plan[k].act;
      c.tslot     = Plan[k].tslot;
      c.handle    = Plan[k].handle;
      c.dly_ms    = Plan[k].dly_ms;
      c.per_ms    = Plan[k].per_ms;
      c.typed     = Plan[k].typed;
      c.typed_res = '{kind: Plan[k].t_kind, slot: Plan[k].t_slot, handle: '0,
                      was_empty: Plan[k].t_empty, last: 1'b1};
      offer(c);
    end

    // The receiver now holds off for a long while. A dispatch goes first so
    // that a reply is parked in the output register and the block backs up.
    hold_asked = 1'b1;
    c = random_cmd();
    c.act = ACT_DISPATCH;
    offer(c);
    for (int unsigned k = 0; k < MixItems; k++) begin
      offer(random_cmd());
    end

    // The sender waits until every owed reply has come back.
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);

    // Fill every free slot, then tick StormTicks times so that pending runs pile
    // up, then let a few dispatch passes emit bursts of runs.
    free_cnt = 0;
    foreach (task_tab[k]) begin
      if (task_tab[k].handle == '0) free_cnt++;
    end
    for (int unsigned k = 0; k < free_cnt; k++) begin
      c = random_cmd();
      c.act    = ACT_ADD;
      c.handle = HandleW'($urandom_range(1, 65535));
      c.dly_ms = ValW'($urandom_range(0, 50));
      c.per_ms = (k % 2 == 0) ? '0 : ValW'($urandom_range(10, 90));
      offer(c);
    end
    for (int unsigned k = 0; k < StormTicks; k++) begin
      c = random_cmd();
      c.act = ACT_TICK;
      offer(c);
    end
    for (int unsigned k = 0; k < 4; k++) begin
      c = random_cmd();
      c.act = ACT_DISPATCH;
      offer(c);
    end

    // Last stretch at full rate on both sides.
    calm = 1'b1;
    for (int unsigned k = 0; k < CalmItems; k++) begin
      offer(random_cmd());
    end
    in_if.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("cooperative_task_tick_scheduler: match");
    end else begin
      $display("cooperative_task_tick_scheduler: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ctts_pkg.sv
rtl/ctts_if.sv
rtl/ctts_div.sv
rtl/ctts_mem.sv
rtl/cooperative_task_tick_scheduler.sv
tb/tb.sv
